[hw/rtl/mcfb_pkg.sv]
// Types, codes and frame constants shared by the motor command frame builder.
package mcfb_pkg;

    localparam int unsigned FRAME_BYTES = 14;
    localparam int unsigned Q_DEPTH     = 2;

    localparam logic [7:0] HDR0     = 8'h55;
    localparam logic [7:0] HDR1     = 8'hAA;
    localparam logic [7:0] INSTR_RD = 8'h01;
    localparam logic [7:0] INSTR_WR = 8'h02;
    localparam logic [7:0] INSTR_CT = 8'h03;
    localparam logic [7:0] POS_RSVD = 8'h10;
    localparam logic [7:0] LEN_BASE = 8'h07;

    localparam logic [3:0] CMD_RD_POS   = 4'd0;
    localparam logic [3:0] CMD_RD_STAT  = 4'd1;
    localparam logic [3:0] CMD_RD_ANGLE = 4'd2;
    localparam logic [3:0] CMD_RD_VER   = 4'd3;
    localparam logic [3:0] CMD_RD_ID    = 4'd4;
    localparam logic [3:0] CMD_SET_ID   = 4'd5;
    localparam logic [3:0] CMD_SET_RED  = 4'd6;
    localparam logic [3:0] CMD_SET_POLE = 4'd7;
    localparam logic [3:0] CMD_START    = 4'd8;
    localparam logic [3:0] CMD_ESTOP    = 4'd9;
    localparam logic [3:0] CMD_PAUSE    = 4'd10;
    localparam logic [3:0] CMD_SAVE     = 4'd11;
    localparam logic [3:0] CMD_CLR      = 4'd12;
    localparam logic [3:0] CMD_SPEED    = 4'd13;
    localparam logic [3:0] CMD_POS      = 4'd14;
    localparam logic [3:0] CMD_POS_SPD  = 4'd15;

    localparam logic [0:0] REG_NODE_ADDR = 1'b0;

    typedef struct packed {
        logic [3:0]  command;
        logic [7:0]  new_id;
        logic [31:0] target_position;
        logic [31:0] target_speed;
        logic [15:0] torque_limit;
    } t_cmd;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_result;

    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [3:0]                  len;
    } t_frame;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [7:0] ctl_code(input logic [3:0] cmd);
        logic [7:0] c;
        case (cmd)
            CMD_RD_POS:   c = 8'h07;
            CMD_RD_STAT:  c = 8'h08;
            CMD_RD_ANGLE: c = 8'h0A;
            CMD_RD_VER:   c = 8'h0B;
            CMD_RD_ID:    c = 8'h01;
            CMD_SET_ID:   c = 8'h15;
            CMD_SET_RED:  c = 8'h16;
            CMD_SET_POLE: c = 8'h17;
            CMD_START:    c = 8'h29;
            CMD_ESTOP:    c = 8'h2A;
            CMD_PAUSE:    c = 8'h2B;
            CMD_SAVE:     c = 8'h2C;
            CMD_CLR:      c = 8'h2D;
            CMD_SPEED:    c = 8'h2F;
            CMD_POS:      c = 8'h31;
            CMD_POS_SPD:  c = 8'h4B;
            default:      c = 8'hFF;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/mcfb_front.sv]
// Front end: classifies a command request and lays out its frame bytes.
module mcfb_front (
    input  mcfb_pkg::t_cmd   i_cmd,
    input  logic [7:0]       i_node_addr,
    output mcfb_pkg::t_frame o_frame
);
    import mcfb_pkg::*;

    logic [7:0] instr;
    logic [3:0] payload;
    logic [FRAME_BYTES-1:0][7:0] b;

    always_comb begin
        if (i_cmd.command <= CMD_RD_ID) begin
            instr   = INSTR_RD;
            payload = 4'd0;
        end else if (i_cmd.command <= CMD_SET_POLE) begin
            instr   = INSTR_WR;
            payload = 4'd1;
        end else if (i_cmd.command <= CMD_CLR) begin
            instr   = INSTR_CT;
            payload = 4'd1;
        end else if (i_cmd.command == CMD_SPEED) begin
            instr   = INSTR_CT;
            payload = 4'd4;
        end else begin
            instr   = INSTR_CT;
            payload = 4'd8;
        end
    end

    always_comb begin
        b     = '0;
        b[0]  = HDR0;
        b[1]  = HDR1;
        b[2]  = LEN_BASE + {4'd0, payload};
        b[3]  = i_node_addr;
        b[4]  = instr;
        b[5]  = ctl_code(i_cmd.command);
        case (i_cmd.command)
            CMD_SET_ID: begin
                b[6] = i_cmd.new_id;
            end
            CMD_SET_RED, CMD_SET_POLE: begin
                b[6] = i_cmd.target_position[7:0];
            end
            CMD_SPEED: begin
                b[6] = i_cmd.target_speed[31:24];
                b[7] = i_cmd.target_speed[23:16];
                b[8] = i_cmd.target_speed[15:8];
                b[9] = i_cmd.target_speed[7:0];
            end
            CMD_POS: begin
                b[6]  = i_cmd.target_position[31:24];
                b[7]  = i_cmd.target_position[23:16];
                b[8]  = i_cmd.target_position[15:8];
                b[9]  = i_cmd.target_position[7:0];
                b[10] = POS_RSVD;
                b[11] = 8'h00;
                b[12] = i_cmd.torque_limit[15:8];
                b[13] = i_cmd.torque_limit[7:0];
            end
            CMD_POS_SPD: begin
                b[6]  = i_cmd.target_position[31:24];
                b[7]  = i_cmd.target_position[23:16];
                b[8]  = i_cmd.target_position[15:8];
                b[9]  = i_cmd.target_position[7:0];
                b[10] = i_cmd.target_speed[31:24];
                b[11] = i_cmd.target_speed[23:16];
                b[12] = i_cmd.target_speed[15:8];
                b[13] = i_cmd.target_speed[7:0];
            end
            default: begin
                b[6] = 8'h00;
            end
        endcase
    end

    assign o_frame.bytes = b;
    assign o_frame.len   = 4'd6 + payload;

endmodule

[hw/rtl/mcfb_queue.sv]
// Two-entry frame queue between the front end and the byte serializer.
module mcfb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mcfb_pkg::t_frame      i_frame,
    input  logic                  i_pop,
    output mcfb_pkg::t_frame      o_head,
    output mcfb_pkg::t_q_status   o_status
);
    import mcfb_pkg::*;

    t_frame     r_ent [Q_DEPTH];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_frame;
        end
    end

    assign o_head          = r_ent[r_rp];
    assign o_status.empty  = (r_count == 2'd0);
    assign o_status.full   = (r_count == 2'(Q_DEPTH));

endmodule

[hw/rtl/mcfb_back.sv]
// Back end: sends the head frame one byte a cycle and appends the checksum.
module mcfb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mcfb_pkg::t_frame     i_head,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_strobe,
    output mcfb_pkg::t_result    o_result
);
    import mcfb_pkg::*;

    logic [3:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic       r_strobe, n_strobe;
    t_result    r_result, n_result;

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_strobe = 1'b0;
        n_result = '0;
        o_pop    = 1'b0;
        if (!i_empty) begin
            n_strobe = 1'b1;
            if (r_pos == i_head.len) begin
                n_result.frame_byte = r_sum;
                n_result.last_byte  = 1'b1;
                o_pop               = 1'b1;
                n_pos               = 4'd0;
                n_sum               = 8'd0;
            end else begin
                n_result.frame_byte = i_head.bytes[r_pos];
                n_pos               = r_pos + 4'd1;
                n_sum               = r_sum + i_head.bytes[r_pos];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 4'd0;
            r_sum    <= 8'd0;
            r_strobe <= 1'b0;
            r_result <= '0;
        end else begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_strobe <= n_strobe;
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[hw/rtl/motor_command_frame_builder.sv]
// Top level of the motor command frame builder: APB register, front, queue, back.
//
//  channel | signals                                  | direction | flow control
//  --------+------------------------------------------+-----------+----------------------
//  command | start, busy, i_cmd                       | in        | taken when start & !busy
//  frame   | o_strobe, o_result                       | out       | one cycle, no stall
//  config  | psel, penable, pwrite, paddr, pwdata ... | in/out    | pready always high
//
// A frame of N bytes (7, 8, 11 or 15, checksum included) leaves the serializer one
// byte a cycle; its first byte appears after the request is registered in the queue
// and in the output register. Back-to-back requests run with no gap between frames.
// busy is high while both queue entries hold frames. Reset clears the queue, the
// serializer state and sets the node address to 1. The receiver cannot stall.
module motor_command_frame_builder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mcfb_pkg::t_cmd        i_cmd,
    output logic                  o_strobe,
    output mcfb_pkg::t_result     o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import mcfb_pkg::*;

    logic      [7:0] r_node_addr;
    logic            accept;
    logic            pop;
    t_frame          frame;
    t_frame          head;
    t_q_status       q_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr <= 8'd1;
        end else if (psel && penable && pwrite && (paddr[2] == REG_NODE_ADDR)) begin
            r_node_addr <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_NODE_ADDR) ? {24'd0, r_node_addr} : 32'd0;

    assign busy   = q_stat.full;
    assign accept = start && !busy;

    mcfb_front u_front (
        .i_cmd       (i_cmd),
        .i_node_addr (r_node_addr),
        .o_frame     (frame)
    );

    mcfb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_frame  (frame),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_stat)
    );

    mcfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (q_stat.empty),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !q_stat.empty)
        else $error("queue empty after accepted request");

    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue both empty and full");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (o_strobe && o_result.last_byte))
        else $error("checksum byte missing after frame pop");

endmodule
